/* rtl/core/ksdt_pkg.sv */
// ----------------------------------------------------------------------------
// ksdt_pkg: shared types and constants of the k-th smallest distance tracker
// Word layouts of both channels, the cell control group and fixed constants.
// ----------------------------------------------------------------------------
package ksdt_pkg;

    // Distance width, unsigned 16.16 fixed point
    localparam int DIST_BITS = 32;

    // k_count register
    localparam int K_COUNT_W = 5;
    localparam logic [K_COUNT_W-1:0] K_COUNT_RESET = 5'd9;

    // All-ones distance: the empty store entry and the saturation value
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef logic [DIST_BITS-1:0] dist_t;

    // Input word
    typedef struct packed {
        logic [31:0] distance;
        logic        is_self;
        logic        last_in_row;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [31:0] kth_distance;
        logic        too_few;
    } out_word_t;

    // Control shared by every cell of the chain
    typedef struct packed {
        logic load;    // a word is accepted this cycle
        logic insert;  // the distance goes into the store
        logic clear;   // end of row: refill with all ones
    } cell_ctrl_t;

endpackage

/* rtl/core/ksdt_cell.sv */
// ----------------------------------------------------------------------------
// ksdt_cell: one entry of the sorted insertion chain
// Holds one stored distance; takes the new distance, its left neighbor's
// entry, or keeps its own, and tells its right neighbor whether the
// insertion point has already been passed.
// ----------------------------------------------------------------------------
module ksdt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ksdt_pkg::cell_ctrl_t ctrl,
    input  logic                active,
    input  ksdt_pkg::dist_t     cand_dist,
    input  logic                prev_found,
    input  ksdt_pkg::dist_t     prev_value,
    output logic                found,
    output ksdt_pkg::dist_t     value,
    output ksdt_pkg::dist_t     ins_value
);

    ksdt_pkg::dist_t value_reg;
    ksdt_pkg::dist_t value_next;
    logic            lt;

    // Compare the new distance against this entry
    assign lt    = (cand_dist < value_reg);
    assign found = prev_found | (active & lt);

    // Shift from the left neighbor, take the new distance, or hold
    always_comb
    begin
        ins_value = value_reg;
        if (ctrl.insert && active)
        begin
            if (prev_found)
            begin
                ins_value = prev_value;
            end
            else if (lt)
            begin
                ins_value = cand_dist;
            end
        end
    end

    // Refill at end of row, else advance to the inserted value
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = ctrl.clear ? ksdt_pkg::DIST_MAX : ins_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= ksdt_pkg::DIST_MAX;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

/* rtl/core/kth_smallest_distance_tracker_core.sv */
// ----------------------------------------------------------------------------
// kth_smallest_distance_tracker_core: k smallest distances of a row
// Keeps the k smallest distances of a row in a sorted chain of cells and
// reports the k-th smallest plus one LSB at the end of each row.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): one distance word per cycle.
//     Words marked is_self are skipped; last_in_row closes the row.
//   out channel (out_valid/out_ready/out_data): one result word per row,
//     the k-th smallest distance plus one LSB (held at all ones) and
//     too_few when fewer than k distances were counted.
//   cfg_write_en/cfg_write_data: write k_count (reset 9); zero acts as 1,
//     values above MAX_K act as MAX_K. Write only while the block is idle.
// Throughput: one word per cycle; every cell compares and shifts in the
//   same cycle, so the compare-and-shift chain of MAX_K cells sets the rate.
// Latency: the result shows up in the cycle after the last word is taken,
//   from a single output register.
// Reset: all entries read all ones, the count is zero, no result pending.
// Stall: while a result waits in the output register and out_ready is low,
//   in_ready stays low; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module kth_smallest_distance_tracker_core #(
    parameter int MAX_K = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ksdt_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ksdt_pkg::out_word_t                 out_data,
    input  logic                                cfg_write_en,
    input  logic [ksdt_pkg::K_COUNT_W-1:0]      cfg_write_data
);

    localparam int SW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam logic [SW-1:0] MAX_K_CNT = SW'(MAX_K);

    logic [ksdt_pkg::K_COUNT_W-1:0] k_count_reg;
    logic [SW-1:0]                  seen_reg;
    logic [SW-1:0]                  seen_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    ksdt_pkg::out_word_t            out_data_reg;
    ksdt_pkg::out_word_t            out_data_next;

    logic [SW-1:0]          k_eff;
    logic [IW-1:0]          kidx;
    logic                   accept;
    ksdt_pkg::dist_t        cand_dist;
    ksdt_pkg::dist_t        bound;
    ksdt_pkg::dist_t        kth;
    ksdt_pkg::cell_ctrl_t   ctrl;

    logic                   found   [MAX_K+1];
    ksdt_pkg::dist_t        chain   [MAX_K+1];
    ksdt_pkg::dist_t        value   [MAX_K];
    ksdt_pkg::dist_t        ins_val [MAX_K];

    // Clamp k into 1..MAX_K
    always_comb
    begin
        if (k_count_reg == '0)
        begin
            k_eff = SW'(1);
        end
        else if (32'(k_count_reg) > MAX_K)
        begin
            k_eff = MAX_K_CNT;
        end
        else
        begin
            k_eff = SW'(k_count_reg);
        end
    end

    assign kidx      = IW'(k_eff - SW'(1));
    assign cand_dist = ksdt_pkg::dist_t'(in_data.distance);
    assign bound     = value[kidx];

    // Take words unless a result waits on a stalled receiver
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Drop self words and words beyond the current boundary
    assign ctrl.load   = accept;
    assign ctrl.insert = !in_data.is_self && !(cand_dist > bound);
    assign ctrl.clear  = in_data.last_in_row;

    // Chain of cells
    assign found[0] = 1'b0;
    assign chain[0] = cand_dist;

    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        ksdt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .active     (SW'(i) < k_eff),
            .cand_dist  (cand_dist),
            .prev_found (found[i]),
            .prev_value (chain[i]),
            .found      (found[i+1]),
            .value      (value[i]),
            .ins_value  (ins_val[i])
        );
        assign chain[i+1] = value[i];
    end

    // Count distances of the row, saturating at MAX_K
    always_comb
    begin
        seen_next = seen_reg;
        if (accept && !in_data.is_self && (seen_reg < MAX_K_CNT))
        begin
            seen_next = seen_reg + SW'(1);
        end
    end

    // Form the result from the store after this word's insertion
    assign kth = ins_val[kidx];

    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && in_data.last_in_row)
        begin
            out_valid_next = 1'b1;
            out_data_next.kth_distance = (kth == ksdt_pkg::DIST_MAX) ?
                32'(kth) : 32'(kth + ksdt_pkg::dist_t'(1));
            out_data_next.too_few = (seen_next < k_eff);
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_count_reg   <= ksdt_pkg::K_COUNT_RESET;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                k_count_reg <= cfg_write_data;
            end
            if (accept && in_data.last_in_row)
            begin
                seen_reg <= '0;
            end
            else
            begin
                seen_reg <= seen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/ksdt_checker.sv */
// ----------------------------------------------------------------------------
// ksdt_checker: port-level checks of the tracker
// Watches the channels of the top level and flags result words that appear,
// vanish or block input at the wrong time.
// ----------------------------------------------------------------------------
module ksdt_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  ksdt_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  ksdt_pkg::out_word_t out_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Closing a row yields a result word next cycle
    a_row_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_in_row |=> out_valid)
        else $error("no result after end of row");

    // No result word without an end of row
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) && !(in_valid && in_ready && in_data.last_in_row)
        |=> !out_valid)
        else $error("result word without end of row");

    // Input blocks while a result waits
    a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

bind kth_smallest_distance_tracker_core ksdt_checker u_ksdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
